// ===== design/bbrs_pkg.sv =====
`default_nettype none
package bbrs_pkg;

	localparam int SRC_WIDTH_DEF  = 256;
	localparam int SRC_HEIGHT_DEF = 256;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int STEP_W     = 20;
	localparam int OFF_W      = 8;
	localparam int COORD_W    = 12;
	localparam int PIX_W      = 8;
	localparam int PW         = STEP_W + COORD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// weights carry 14 fraction bits; 15 bits leave headroom
	localparam int WBITS    = 14;
	localparam int WW       = WBITS + 1;
	// quotient numerator after the pre-shift, and its divide-by-6 reciprocal
	localparam int VW       = 17;
	localparam int RECIP_W  = 16;
	localparam int RECIP6   = 43691;
	localparam int RECIP_SH = 18;
	localparam int ACC_W    = 40;

	localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd3;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   red_in;
		logic [PIX_W-1:0]   green_in;
		logic [PIX_W-1:0]   blue_in;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAP, ST_MUL, ST_WGT, ST_TAP, ST_DRAIN, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MOP_NONE, MOP_FSQ, MOP_FLO, MOP_FHI, MOP_GSQ, MOP_GLO, MOP_GHI
	} mop_t;

	typedef struct packed {
		logic       wr;
		logic       load;
		logic       map;
		mop_t       mop;
		logic       axis;
		logic       num_en;
		logic [1:0] num_idx;
		logic       div_en;
		logic [1:0] div_idx;
		logic       tap_en;
		logic [1:0] tap_m;
		logic [1:0] tap_n;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/bspline_bicubic_region_scaler_top.sv =====
`default_nettype none
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------
// item      | item_valid / item_stall    | item   (bbrs_pkg::item_t)
// result    | result_valid / result_stall| result (bbrs_pkg::result_t)
// config    | wr_en                      | wr_index, wr_data
//
// A write beat is accepted in idle and leaves the block idle. A compute beat runs
// from accept to the next accept: 12 passes through one shared multiplier for the
// weights, 10 numerator/divide steps, 16 reads of the single-port image store, a drain.
// The image store has no clear after reset; its entries hold garbage until written.
// A result held by result_stall delays only the next compute's final cycle.
module bspline_bicubic_region_scaler_top #(
	parameter int SRC_WIDTH  = bbrs_pkg::SRC_WIDTH_DEF,
	parameter int SRC_HEIGHT = bbrs_pkg::SRC_HEIGHT_DEF,
	parameter int FRAC_BITS  = bbrs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire bbrs_pkg::item_t                 item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output bbrs_pkg::result_t                    result,
	input  wire logic                            wr_en,
	input  wire logic [bbrs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bbrs_pkg::CFG_DATA_W-1:0] wr_data
);

	bbrs_pkg::cmd_t cmd;
	bbrs_pkg::sts_t sts;

	bbrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	bbrs_dp #(
		.SRC_WIDTH  (SRC_WIDTH),
		.SRC_HEIGHT (SRC_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== design/bbrs_ctrl.sv =====
`default_nettype none
module bbrs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	input  wire logic          item_op,
	output logic               item_stall,
	input  wire bbrs_pkg::sts_t sts,
	output bbrs_pkg::cmd_t     cmd
);

	bbrs_pkg::state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbrs_pkg::ST_IDLE;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		cnt_d      = cnt_q;
		axis_d     = axis_q;
		item_stall = 1'b1;
		unique case (state_q)
			bbrs_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (item_op == bbrs_pkg::OP_COMPUTE) begin
						cmd.load = 1'b1;
						state_d  = bbrs_pkg::ST_MAP;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			bbrs_pkg::ST_MAP: begin
				cmd.map = 1'b1;
				cnt_d   = '0;
				axis_d  = 1'b0;
				state_d = bbrs_pkg::ST_MUL;
			end
			bbrs_pkg::ST_MUL: begin
				cmd.axis = axis_q;
				unique case (cnt_q[2:0])
					3'd0: cmd.mop = bbrs_pkg::MOP_FSQ;
					3'd1: cmd.mop = bbrs_pkg::MOP_FLO;
					3'd2: cmd.mop = bbrs_pkg::MOP_FHI;
					3'd3: cmd.mop = bbrs_pkg::MOP_GSQ;
					3'd4: cmd.mop = bbrs_pkg::MOP_GLO;
					default: cmd.mop = bbrs_pkg::MOP_GHI;
				endcase
				if (cnt_q == 4'd5) begin
					cnt_d   = '0;
					state_d = bbrs_pkg::ST_WGT;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			bbrs_pkg::ST_WGT: begin
				// numerator for tap i overlaps the divide of tap i-1
				cmd.axis    = axis_q;
				cmd.num_en  = (cnt_q < 4'd4);
				cmd.num_idx = cnt_q[1:0];
				cmd.div_en  = (cnt_q != 4'd0);
				cmd.div_idx = cnt_q[1:0] - 2'd1;
				if (cnt_q == 4'd4) begin
					cnt_d = '0;
					if (axis_q) begin
						state_d = bbrs_pkg::ST_TAP;
					end else begin
						axis_d  = 1'b1;
						state_d = bbrs_pkg::ST_MUL;
					end
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			bbrs_pkg::ST_TAP: begin
				cmd.tap_en = 1'b1;
				cmd.tap_m  = cnt_q[3:2];
				cmd.tap_n  = cnt_q[1:0];
				if (cnt_q == 4'd15) begin
					cnt_d   = '0;
					state_d = bbrs_pkg::ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			bbrs_pkg::ST_DRAIN: begin
				if (cnt_q == 4'd1) begin
					cnt_d   = '0;
					state_d = bbrs_pkg::ST_FIN;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			bbrs_pkg::ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = bbrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bbrs_pkg::ST_IDLE;
			end
		endcase
	end

	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbrs_pkg::ST_IDLE && item_valid && item_op == bbrs_pkg::OP_COMPUTE)
		|=> state_q == bbrs_pkg::ST_MAP)
		else $error("compute beat did not start mapping");

	a_taps_sixteen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbrs_pkg::ST_TAP && cnt_q == 4'd15) |=> state_q == bbrs_pkg::ST_DRAIN)
		else $error("tap sweep did not end after sixteen reads");

endmodule
`default_nettype wire

// ===== design/bbrs_dp.sv =====
`default_nettype none
module bbrs_dp #(
	parameter int SRC_WIDTH  = bbrs_pkg::SRC_WIDTH_DEF,
	parameter int SRC_HEIGHT = bbrs_pkg::SRC_HEIGHT_DEF,
	parameter int FRAC_BITS  = bbrs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [bbrs_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [bbrs_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire bbrs_pkg::item_t                   item,
	input  wire bbrs_pkg::cmd_t                    cmd,
	output bbrs_pkg::sts_t                         sts,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output bbrs_pkg::result_t                      result
);

	localparam int MW    = FRAC_BITS + 1;
	localparam int NW    = 3 * MW;
	localparam int K     = 3 * FRAC_BITS - bbrs_pkg::WBITS;
	localparam int XBW   = bbrs_pkg::PW - FRAC_BITS + 1;
	localparam int LW    = XBW + $clog2(SRC_WIDTH) + 3;
	localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int IMAX  = DEPTH - 1;
	localparam int WAW   = 2 * bbrs_pkg::COORD_W;
	localparam int DPW   = bbrs_pkg::VW + bbrs_pkg::RECIP_W;
	localparam int PXW   = 3 * bbrs_pkg::PIX_W;
	localparam int RSH   = 2 * bbrs_pkg::WBITS;
	localparam logic [MW-1:0] S_ONE = MW'(1) << FRAC_BITS;
	localparam logic [NW-1:0] S3    = NW'(1) << (3 * FRAC_BITS);

	function automatic logic [bbrs_pkg::PIX_W-1:0] rnd_sat(
		input logic [bbrs_pkg::ACC_W-1:0] a
	);
		logic [bbrs_pkg::ACC_W-1:0]     s;
		logic [bbrs_pkg::ACC_W-RSH-1:0] v;
		s = a + (bbrs_pkg::ACC_W'(1) << (RSH - 1));
		v = s[bbrs_pkg::ACC_W-1:RSH];
		if (v > (bbrs_pkg::ACC_W-RSH)'(255))
			return 8'hff;
		return v[bbrs_pkg::PIX_W-1:0];
	endfunction

	// configuration
	logic [bbrs_pkg::STEP_W-1:0] step_x_q, step_y_q;
	logic [bbrs_pkg::OFF_W-1:0]  offset_x_q, offset_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= bbrs_pkg::STEP_RESET;
			step_y_q   <= bbrs_pkg::STEP_RESET;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				bbrs_pkg::CFG_STEP_X:   step_x_q   <= wr_data;
				bbrs_pkg::CFG_STEP_Y:   step_y_q   <= wr_data;
				bbrs_pkg::CFG_OFFSET_X: offset_x_q <= wr_data[bbrs_pkg::OFF_W-1:0];
				bbrs_pkg::CFG_OFFSET_Y: offset_y_q <= wr_data[bbrs_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// item latch and coordinate mapping
	logic [bbrs_pkg::COORD_W-1:0] col_q, row_q;
	logic [bbrs_pkg::PW-1:0]      pxm, pym;
	logic [FRAC_BITS-1:0]         fx_q, fy_q;
	logic [XBW-1:0]               xb_q, yb_q;

	assign pxm = bbrs_pkg::PW'(step_x_q) * bbrs_pkg::PW'(col_q);
	assign pym = bbrs_pkg::PW'(step_y_q) * bbrs_pkg::PW'(row_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= item.col;
			row_q <= item.row;
		end
		if (cmd.map) begin
			fx_q <= pxm[FRAC_BITS-1:0];
			fy_q <= pym[FRAC_BITS-1:0];
			xb_q <= XBW'(pxm[bbrs_pkg::PW-1:FRAC_BITS]) + XBW'(offset_x_q);
			yb_q <= XBW'(pym[bbrs_pkg::PW-1:FRAC_BITS]) + XBW'(offset_y_q);
		end
	end

	// shared multiplier: squares and cubes of f and 1-f, cubes in two halves
	logic [MW-1:0]     f_sel, g_sel, ma, mb;
	logic [2*MW-1:0]   mprod, sqf_q, sqg_q, lo_q;
	logic [NW-1:0]     cubef_q, cubeg_q, num, num_q, fn;

	assign f_sel = MW'(cmd.axis ? fy_q : fx_q);
	assign g_sel = S_ONE - f_sel;
	assign mprod = {{MW{1'b0}}, ma} * {{MW{1'b0}}, mb};

	always_comb begin
		unique case (cmd.mop)
			bbrs_pkg::MOP_FLO: begin ma = sqf_q[MW-1:0];    mb = f_sel; end
			bbrs_pkg::MOP_FHI: begin ma = sqf_q[2*MW-1:MW]; mb = f_sel; end
			bbrs_pkg::MOP_GSQ: begin ma = g_sel;            mb = g_sel; end
			bbrs_pkg::MOP_GLO: begin ma = sqg_q[MW-1:0];    mb = g_sel; end
			bbrs_pkg::MOP_GHI: begin ma = sqg_q[2*MW-1:MW]; mb = g_sel; end
			default:           begin ma = f_sel;            mb = f_sel; end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.mop)
			bbrs_pkg::MOP_FSQ: sqf_q   <= mprod;
			bbrs_pkg::MOP_FLO: lo_q    <= mprod;
			bbrs_pkg::MOP_FHI: cubef_q <= {mprod, {MW{1'b0}}} + NW'(lo_q);
			bbrs_pkg::MOP_GSQ: sqg_q   <= mprod;
			bbrs_pkg::MOP_GLO: lo_q    <= mprod;
			bbrs_pkg::MOP_GHI: cubeg_q <= {mprod, {MW{1'b0}}} + NW'(lo_q);
			default: ;
		endcase
	end

	// kernel numerators, scale 6*S^3
	assign fn = NW'(f_sel);

	always_comb begin
		unique case (cmd.num_idx)
			2'd0: num = cubeg_q;
			2'd1: num = (S3 << 2) + cubef_q * NW'(3)
				- ((NW'(sqf_q) * NW'(6)) << FRAC_BITS);
			2'd2: num = S3 + ((fn * NW'(3)) << (2 * FRAC_BITS))
				+ ((NW'(sqf_q) * NW'(3)) << FRAC_BITS) - cubef_q * NW'(3);
			default: num = cubef_q;
		endcase
	end

	// round-to-nearest divide by 6*2^K: shift, then reciprocal multiply
	logic [bbrs_pkg::VW-1:0] dsum;
	logic [DPW-1:0]          dprod;
	logic [bbrs_pkg::WW-1:0] wq;
	logic [bbrs_pkg::WW-1:0] wx_q [4];
	logic [bbrs_pkg::WW-1:0] wy_q [4];

	assign dsum  = num_q[NW-1:K] + bbrs_pkg::VW'(3);
	assign dprod = DPW'(dsum) * DPW'(bbrs_pkg::RECIP6);
	assign wq    = dprod[bbrs_pkg::RECIP_SH +: bbrs_pkg::WW];

	always_ff @(posedge clk) begin
		if (cmd.num_en)
			num_q <= num;
		if (cmd.div_en) begin
			if (cmd.axis)
				wy_q[cmd.div_idx] <= wq;
			else
				wx_q[cmd.div_idx] <= wq;
		end
	end

	// tap address with linear clamp
	logic [LW-1:0] txl, tyl, lin;
	logic [AW-1:0] radr;

	assign txl = LW'(xb_q) + LW'(cmd.tap_m) - LW'(1);
	assign tyl = LW'(yb_q) + LW'(cmd.tap_n) - LW'(1);
	assign lin = tyl * LW'(SRC_WIDTH) + txl;

	always_comb begin
		if (lin[LW-1])
			radr = '0;
		else if (lin > LW'(IMAX))
			radr = AW'(IMAX);
		else
			radr = lin[AW-1:0];
	end

	// source write address
	logic [WAW-1:0] wadr;
	logic           wok;

	assign wadr = WAW'(item.row) * WAW'(SRC_WIDTH) + WAW'(item.col);
	assign wok  = ({1'b0, item.col} < (bbrs_pkg::COORD_W+1)'(SRC_WIDTH))
		&& ({1'b0, item.row} < (bbrs_pkg::COORD_W+1)'(SRC_HEIGHT));

	// image store and tap pipeline
	logic [PXW-1:0]          mem [DEPTH];
	logic [AW-1:0]           adr_s1;
	logic [2*bbrs_pkg::WW-1:0] wp_s1, wp_s2;
	logic [PXW-1:0]          pix_s2;
	logic                    v_s1, v_s2;

	always_ff @(posedge clk) begin
		if (cmd.wr && wok)
			mem[wadr[AW-1:0]] <= {item.red_in, item.green_in, item.blue_in};
		pix_s2 <= mem[adr_s1];
	end

	always_ff @(posedge clk) begin
		adr_s1 <= radr;
		wp_s1  <= (2*bbrs_pkg::WW)'(wx_q[cmd.tap_m]) * (2*bbrs_pkg::WW)'(wy_q[cmd.tap_n]);
		wp_s2  <= wp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.tap_en;
			v_s2 <= v_s1;
		end
	end

	logic [bbrs_pkg::ACC_W-1:0] acc_q [3];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end else if (v_s2) begin
			acc_q[0] <= acc_q[0] + bbrs_pkg::ACC_W'(pix_s2[23:16]) * bbrs_pkg::ACC_W'(wp_s2);
			acc_q[1] <= acc_q[1] + bbrs_pkg::ACC_W'(pix_s2[15:8]) * bbrs_pkg::ACC_W'(wp_s2);
			acc_q[2] <= acc_q[2] + bbrs_pkg::ACC_W'(pix_s2[7:0]) * bbrs_pkg::ACC_W'(wp_s2);
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.red_out   <= rnd_sat(acc_q[0]);
			result.green_out <= rnd_sat(acc_q[1]);
			result.blue_out  <= rnd_sat(acc_q[2]);
		end
	end

	assign result_valid = out_valid_q;
	assign sts.out_busy = out_valid_q && result_stall;

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result beat raised without a finished compute");

	a_tap_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap_en |=> ##1 v_s2)
		else $error("tap read lost in pipeline");

endmodule
`default_nettype wire
